FILE: rtl/variable_record_ring_fifo_assert.svh
// Assertion macros for the variable record ring FIFO.
`ifndef VARIABLE_RECORD_RING_FIFO_ASSERT_SVH
`define VARIABLE_RECORD_RING_FIFO_ASSERT_SVH

`ifndef SYNTHESIS
// Checked outside reset.
`define VRRF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked on every edge, reset included.
`define VRRF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define VRRF_ASSERT(lbl, prop, msg)
`define VRRF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/vrrf_pkg.sv
// Shared types and codes for the variable record ring FIFO.
package vrrf_pkg;

    localparam int LEN_W  = 7;
    localparam int BYTE_W = 8;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 3;
    localparam int IN_W   = 24;  // len + byte + capacity, padded to bytes

    localparam logic [CMD_W-1:0] CMD_PUSH_HDR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BYTE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP       = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK     = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_SMALL  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_MISUSE = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             push_open;
        logic             len_bad;
        logic             no_room;
        logic             empty;
        logic             rlen_small;
        logic             rlen_zero;
        logic             cnt_last;
        logic             out_free;
    } vrrf_sts_t;

    typedef struct packed {
        logic              latch_in;
        logic              wr_hdr;
        logic              wr_byte;
        logic              rd_hdr;
        logic              hdr_start;
        logic              rd_next;
        logic              pop_zero;
        logic              out_load;
        logic [STAT_W-1:0] out_status;
        logic              out_byte;
        logic              out_last;
    } vrrf_ctl_t;

endpackage

FILE: rtl/vrrf_datapath.sv
// Datapath: byte store, pointers, input latch and output register.
module vrrf_datapath #(
    parameter int STORE_DEPTH = 4096,
    parameter int MAX_RECORD  = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [vrrf_pkg::IN_W-1:0]   s_tdata,
    input  logic [vrrf_pkg::CMD_W-1:0]  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [vrrf_pkg::BYTE_W-1:0] m_tdata,
    output logic [vrrf_pkg::STAT_W-1:0] m_tuser,
    output logic                        m_tlast,
    input  vrrf_pkg::vrrf_ctl_t         ctl,
    output vrrf_pkg::vrrf_sts_t         sts
);

    `include "variable_record_ring_fifo_assert.svh"

    localparam int SPAN = 2 * STORE_DEPTH;
    localparam int PW   = $clog2(SPAN);
    localparam int AW   = $clog2(STORE_DEPTH);
    localparam int LW   = vrrf_pkg::LEN_W;
    localparam int BW   = vrrf_pkg::BYTE_W;

    function automatic logic [AW-1:0] slot_of(input logic [PW-1:0] p);
        logic [PW-1:0] s;
        begin
            s = (p >= PW'(STORE_DEPTH)) ? p - PW'(STORE_DEPTH) : p;
            slot_of = s[AW-1:0];
        end
    endfunction

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        ptr_next = (p == PW'(SPAN - 1)) ? '0 : p + PW'(1);
    endfunction

    // latched input item
    logic [vrrf_pkg::CMD_W-1:0] cmd_reg;
    logic [LW-1:0]              len_reg;
    logic [BW-1:0]              din_reg;
    logic [LW-1:0]              cap_reg;

    // control state
    logic [PW-1:0] top_reg, top_next;
    logic [PW-1:0] bot_reg, bot_next;
    logic [PW-1:0] wc_reg, wc_next;
    logic [LW-1:0] rem_reg, rem_next;
    logic          open_reg, open_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;

    // output payload
    logic [BW-1:0]                 out_data_reg;
    logic [vrrf_pkg::STAT_W-1:0]   out_status_reg;
    logic                          out_last_reg;

    // store
    logic [BW-1:0] mem [STORE_DEPTH];
    logic [BW-1:0] rd_data_reg;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [BW-1:0] wr_data;

    logic [PW:0]   used;
    logic [PW+1:0] need;
    logic [LW-1:0] rlen, rlen_c;
    logic          out_free;

    always_comb begin
        if (top_reg >= bot_reg) begin
            used = {1'b0, top_reg} - {1'b0, bot_reg};
        end else begin
            used = {1'b0, top_reg} + (PW+1)'(SPAN) - {1'b0, bot_reg};
        end
        need   = {1'b0, used} + (PW+2)'(len_reg) + (PW+2)'(1);
        rlen   = rd_data_reg[LW-1:0];
        rlen_c = (rlen > LW'(MAX_RECORD)) ? LW'(MAX_RECORD) : rlen;
    end

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        sts.cmd        = cmd_reg;
        sts.push_open  = open_reg;
        sts.len_bad    = (len_reg == '0) || (len_reg > LW'(MAX_RECORD));
        sts.no_room    = need > (PW+2)'(STORE_DEPTH);
        sts.empty      = (top_reg == bot_reg);
        sts.rlen_small = rlen_c > cap_reg;
        sts.rlen_zero  = (rlen_c == '0);
        sts.cnt_last   = (cnt_reg == LW'(1));
        sts.out_free   = out_free;
    end

    // store port selection
    always_comb begin
        wr_en   = ctl.wr_hdr || ctl.wr_byte;
        wr_addr = ctl.wr_hdr ? slot_of(top_reg) : slot_of(wc_reg);
        wr_data = ctl.wr_hdr ? BW'(len_reg) : din_reg;
        rd_en   = ctl.rd_hdr || ctl.hdr_start || ctl.rd_next;
        if (ctl.rd_hdr) begin
            rd_addr = slot_of(bot_reg);
        end else if (ctl.hdr_start) begin
            rd_addr = slot_of(ptr_next(bot_reg));
        end else begin
            rd_addr = slot_of(ptr_next(rd_ptr_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // pointer updates
    always_comb begin
        top_next    = top_reg;
        bot_next    = bot_reg;
        wc_next     = wc_reg;
        rem_next    = rem_reg;
        open_next   = open_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (ctl.wr_hdr) begin
            wc_next   = ptr_next(top_reg);
            rem_next  = len_reg;
            open_next = 1'b1;
        end
        if (ctl.wr_byte) begin
            wc_next = ptr_next(wc_reg);
            if (rem_reg > LW'(1)) begin
                rem_next = rem_reg - LW'(1);
            end else begin
                rem_next  = '0;
                top_next  = ptr_next(wc_reg);
                open_next = 1'b0;
            end
        end
        if (ctl.pop_zero) begin
            bot_next = ptr_next(bot_reg);
        end
        if (ctl.hdr_start) begin
            rd_ptr_next = ptr_next(bot_reg);
            cnt_next    = rlen_c;
        end
        if (ctl.rd_next) begin
            rd_ptr_next = ptr_next(rd_ptr_reg);
            cnt_next    = cnt_reg - LW'(1);
            if (cnt_reg == LW'(1)) begin
                bot_next = ptr_next(rd_ptr_reg);
            end
        end
        if (ctl.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg       <= '0;
            bot_reg       <= '0;
            wc_reg        <= '0;
            rem_reg       <= '0;
            open_reg      <= 1'b0;
            rd_ptr_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            top_reg       <= top_next;
            bot_reg       <= bot_next;
            wc_reg        <= wc_next;
            rem_reg       <= rem_next;
            open_reg      <= open_next;
            rd_ptr_reg    <= rd_ptr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.latch_in) begin
            cmd_reg <= s_tuser;
            len_reg <= s_tdata[LW-1:0];
            din_reg <= s_tdata[LW+BW-1:LW];
            cap_reg <= s_tdata[2*LW+BW-1:LW+BW];
        end
        if (ctl.out_load) begin
            out_status_reg <= ctl.out_status;
            out_data_reg   <= ctl.out_byte ? rd_data_reg : '0;
            out_last_reg   <= ctl.out_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    `VRRF_ASSERT(a_open_owes_bytes, open_reg |-> (rem_reg != '0), "open record owes no bytes")
    `VRRF_ASSERT(a_used_bounded, used <= (PW+1)'(STORE_DEPTH), "committed bytes exceed store")
    `VRRF_ASSERT(a_hdr_when_closed, ctl.wr_hdr |-> !open_reg, "header written into open record")
    `VRRF_ASSERT(a_load_when_free, ctl.out_load |-> out_free, "output register overwritten")
    `VRRF_ASSERT(a_read_count, ctl.rd_next |-> (cnt_reg != '0), "payload read past record end")

endmodule

FILE: rtl/vrrf_ctrl.sv
// Controller: sequences one item through execute, header read and payload emit.
module vrrf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  vrrf_pkg::vrrf_sts_t sts,
    output vrrf_pkg::vrrf_ctl_t ctl
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_HDR  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        ctl            = '0;
        ctl.out_status = vrrf_pkg::STAT_OK;
        ctl.out_last   = 1'b1;
        state_next     = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ctl.latch_in = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (sts.cmd)
                    vrrf_pkg::CMD_PUSH_HDR: begin
                        if (sts.out_free) begin
                            ctl.out_load = 1'b1;
                            state_next   = ST_IDLE;
                            if (sts.push_open || sts.len_bad) begin
                                ctl.out_status = vrrf_pkg::STAT_MISUSE;
                            end else if (sts.no_room) begin
                                ctl.out_status = vrrf_pkg::STAT_FULL;
                            end else begin
                                ctl.wr_hdr = 1'b1;
                            end
                        end
                    end
                    vrrf_pkg::CMD_PUSH_BYTE: begin
                        if (sts.out_free) begin
                            ctl.out_load = 1'b1;
                            state_next   = ST_IDLE;
                            if (sts.push_open) begin
                                ctl.wr_byte = 1'b1;
                            end else begin
                                ctl.out_status = vrrf_pkg::STAT_MISUSE;
                            end
                        end
                    end
                    vrrf_pkg::CMD_POP: begin
                        if (!sts.empty) begin
                            ctl.rd_hdr = 1'b1;
                            state_next = ST_HDR;
                        end else if (sts.out_free) begin
                            ctl.out_load   = 1'b1;
                            ctl.out_status = vrrf_pkg::STAT_EMPTY;
                            state_next     = ST_IDLE;
                        end
                    end
                    default: begin
                        if (sts.out_free) begin
                            ctl.out_load   = 1'b1;
                            ctl.out_status = vrrf_pkg::STAT_MISUSE;
                            state_next     = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_HDR: begin
                if (sts.rlen_small) begin
                    if (sts.out_free) begin
                        ctl.out_load   = 1'b1;
                        ctl.out_status = vrrf_pkg::STAT_SMALL;
                        state_next     = ST_IDLE;
                    end
                end else if (sts.rlen_zero) begin
                    if (sts.out_free) begin
                        ctl.out_load = 1'b1;
                        ctl.pop_zero = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    ctl.hdr_start = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    ctl.out_load = 1'b1;
                    ctl.out_byte = 1'b1;
                    ctl.out_last = sts.cnt_last;
                    ctl.rd_next  = 1'b1;
                    if (sts.cnt_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/variable_record_ring_fifo.sv
// Top level of the variable record ring FIFO: controller plus datapath.
//
// Channel   Direction  tdata (low bit up)                         tuser      tlast
// s_        in         record_length[6:0] data_in[14:7]            command    -
//                      capacity[21:15] zero[23:22]
// m_        out        data_out[7:0]                              status     last
//
// Push header, push byte, unused command and empty pop: accept, then execute
// loads the output register. A pop reads the header in the execute cycle and
// checks it the next: a too-small reject then loads its result, and an n-byte
// record streams one byte per cycle, while the output register is free, out of
// the single read port of the byte store.
// A new item is taken as soon as the previous one has put its last result
// into the output register; that result may still be waiting on m_tready.
// m_tready low stalls the controller only where it must load a result.
// aresetn (synchronous) empties the queue; the byte store is not cleared.
module variable_record_ring_fifo #(
    parameter int STORE_DEPTH = 4096,   // bytes in the ring store
    parameter int MAX_RECORD  = 64      // longest record payload
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input items
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // record_length[6:0], data_in[14:7], capacity[21:15], zero[23:22]
    input  logic [vrrf_pkg::IN_W-1:0]   s_tdata,
    // command[1:0]
    input  logic [vrrf_pkg::CMD_W-1:0]  s_tuser,
    // result items
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // data_out[7:0]
    output logic [vrrf_pkg::BYTE_W-1:0] m_tdata,
    // status[2:0]
    output logic [vrrf_pkg::STAT_W-1:0] m_tuser,
    output logic                        m_tlast
);

    vrrf_pkg::vrrf_ctl_t ctl;
    vrrf_pkg::vrrf_sts_t sts;

    // Sequencer: one item at a time through execute / header / emit.
    vrrf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // Byte store, ring pointers and the output register.
    vrrf_datapath #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_RECORD  (MAX_RECORD)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .ctl      (ctl),
        .sts      (sts)
    );

endmodule

FILE: dv/variable_record_ring_fifo_tb.sv
// Self-checking testbench for the variable record ring FIFO: directed table, hold-off, random mix.
module variable_record_ring_fifo_tb;

    localparam int LEN_W       = vrrf_pkg::LEN_W;
    localparam int BYTE_W      = vrrf_pkg::BYTE_W;
    localparam int CMD_W       = vrrf_pkg::CMD_W;
    localparam int STAT_W      = vrrf_pkg::STAT_W;
    localparam int IN_W        = vrrf_pkg::IN_W;

    localparam int DEPTH       = 4096;
    localparam int MAX_LEN     = 64;
    localparam int HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 80;
    localparam int PHASE_ITEMS = 95;
    localparam int PRINT_LIMIT = 30;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BYTE_W-1:0] data;
        logic              last;
    } fifo_out_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] din;
        logic [LEN_W-1:0]  cap;
        logic              fixed;   // expected status typed in below
        logic [STAT_W-1:0] want;
    } stim_row_t;

    // Rows with fixed = 0 are checked against the predictor (pops that stream bytes).
    stim_row_t directed_rows [20] = '{
        '{vrrf_pkg::CMD_POP,       7'd0,   8'h00, 7'd64,  1'b1, vrrf_pkg::STAT_EMPTY},  // after reset
        '{vrrf_pkg::CMD_PUSH_BYTE, 7'd0,   8'hAA, 7'd0,   1'b1, vrrf_pkg::STAT_MISUSE}, // stray byte
        '{vrrf_pkg::CMD_PUSH_HDR,  7'd0,   8'h00, 7'd0,   1'b1, vrrf_pkg::STAT_MISUSE}, // zero length
        '{vrrf_pkg::CMD_PUSH_HDR,  7'd65,  8'h00, 7'd0,   1'b1, vrrf_pkg::STAT_MISUSE}, // over max
        '{vrrf_pkg::CMD_PUSH_HDR,  7'd127, 8'hFF, 7'd127, 1'b1, vrrf_pkg::STAT_MISUSE}, // all ones
        '{CMD_UNUSED,              7'd5,   8'h33, 7'd9,   1'b1, vrrf_pkg::STAT_MISUSE},
        '{vrrf_pkg::CMD_PUSH_HDR,  7'd1,   8'h00, 7'd0,   1'b1, vrrf_pkg::STAT_OK},
        '{vrrf_pkg::CMD_PUSH_HDR,  7'd5,   8'h00, 7'd0,   1'b1, vrrf_pkg::STAT_MISUSE}, // while open
        '{vrrf_pkg::CMD_POP,       7'd0,   8'h00, 7'd64,  1'b1, vrrf_pkg::STAT_EMPTY},  // uncommitted
        '{vrrf_pkg::CMD_PUSH_BYTE, 7'd0,   8'hFF, 7'd0,   1'b1, vrrf_pkg::STAT_OK},
        '{vrrf_pkg::CMD_PUSH_HDR,  7'd3,   8'h00, 7'd0,   1'b1, vrrf_pkg::STAT_OK},
        '{vrrf_pkg::CMD_POP,       7'd0,   8'h00, 7'd0,   1'b1, vrrf_pkg::STAT_SMALL},  // too small
        '{vrrf_pkg::CMD_POP,       7'd0,   8'h00, 7'd1,   1'b0, vrrf_pkg::STAT_OK},     // mid-push
        '{vrrf_pkg::CMD_PUSH_BYTE, 7'd0,   8'h00, 7'd0,   1'b1, vrrf_pkg::STAT_OK},
        '{vrrf_pkg::CMD_POP,       7'd0,   8'h00, 7'd127, 1'b1, vrrf_pkg::STAT_EMPTY},
        '{vrrf_pkg::CMD_PUSH_BYTE, 7'd0,   8'h80, 7'd0,   1'b1, vrrf_pkg::STAT_OK},
        '{vrrf_pkg::CMD_PUSH_BYTE, 7'd0,   8'h7F, 7'd0,   1'b1, vrrf_pkg::STAT_OK},
        '{vrrf_pkg::CMD_POP,       7'd0,   8'h00, 7'd2,   1'b1, vrrf_pkg::STAT_SMALL},
        '{vrrf_pkg::CMD_POP,       7'd0,   8'h00, 7'd3,   1'b0, vrrf_pkg::STAT_OK},
        '{vrrf_pkg::CMD_POP,       7'd0,   8'h00, 7'd0,   1'b1, vrrf_pkg::STAT_EMPTY}
    };

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata  = '0;
    logic [CMD_W-1:0]    s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b1;
    logic [BYTE_W-1:0]   m_tdata;
    logic [STAT_W-1:0]   m_tuser;
    logic                m_tlast;

    // shadow copy of the ring
    logic [BYTE_W-1:0]   shadow_mem [DEPTH];
    logic [12:0]         shadow_top  = '0;
    logic [12:0]         shadow_bot  = '0;
    logic [12:0]         shadow_wr   = '0;
    logic [LEN_W-1:0]    shadow_owed = '0;
    logic                shadow_open = 1'b0;

    fifo_out_t           pending_outputs [$];

    int items_sent;
    int outputs_checked;
    int mismatch_count;
    int cycle_count;
    int status_tally [5];
    int send_idle_pct;
    int recv_stall_pct;
    int hold_asks;
    int hold_seen;
    int hold_left;
    int phase_goal;
    int send_pct_by_phase [4] = '{0, 82, 0, 30};
    int recv_pct_by_phase [4] = '{0, 0, 82, 30};

    variable_record_ring_fifo dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("MISMATCH %s: got %0h, expected %0h (output %0d, cycle %0d)",
                     what, got, want, outputs_checked, cycle_count);
    endtask

    // Applies one accepted item to the shadow ring and queues its outputs.
    function automatic void predict_ring_fifo(input logic [CMD_W-1:0] cmd,
                                              input logic [LEN_W-1:0] len,
                                              input logic [BYTE_W-1:0] din,
                                              input logic [LEN_W-1:0] cap,
                                              input bit queue_it);
        logic [12:0]       used;
        logic [12:0]       rd;
        logic [STAT_W-1:0] st;
        int                room;
        int                rlen;
        bit                streamed;
        fifo_out_t         o;
        used     = shadow_top - shadow_bot;
        room     = DEPTH - int'(used);
        st       = vrrf_pkg::STAT_OK;
        streamed = 1'b0;
        case (cmd)
            vrrf_pkg::CMD_PUSH_HDR: begin
                if (shadow_open || len == 0 || int'(len) > MAX_LEN) begin
                    st = vrrf_pkg::STAT_MISUSE;
                end else if (int'(len) + 1 > room) begin
                    st = vrrf_pkg::STAT_FULL;
                end else begin
                    shadow_mem[shadow_top[11:0]] = {1'b0, len};
                    shadow_wr   = shadow_top + 13'd1;
                    shadow_owed = len;
                    shadow_open = 1'b1;
                end
            end
            vrrf_pkg::CMD_PUSH_BYTE: begin
                if (!shadow_open) begin
                    st = vrrf_pkg::STAT_MISUSE;
                end else begin
                    shadow_mem[shadow_wr[11:0]] = din;
                    shadow_wr = shadow_wr + 13'd1;
                    if (shadow_owed != 0) shadow_owed = shadow_owed - 7'd1;
                    if (shadow_owed == 0) begin
                        shadow_top  = shadow_wr;   // commit
                        shadow_open = 1'b0;
                    end
                end
            end
            vrrf_pkg::CMD_POP: begin
                if (used == 0) begin
                    st = vrrf_pkg::STAT_EMPTY;
                end else begin
                    rlen = int'(shadow_mem[shadow_bot[11:0]] & 8'h7F);
                    if (rlen > MAX_LEN) rlen = MAX_LEN;
                    if (rlen > int'(cap)) begin
                        st = vrrf_pkg::STAT_SMALL;
                    end else begin
                        rd = shadow_bot + 13'd1;
                        for (int k = 0; k < rlen; k++) begin
                            o.status = vrrf_pkg::STAT_OK;
                            o.data   = shadow_mem[rd[11:0]];
                            o.last   = (k + 1 == rlen);
                            if (queue_it) pending_outputs.push_back(o);
                            rd = rd + 13'd1;
                        end
                        shadow_bot = rd;
                        streamed   = (rlen != 0);
                    end
                end
            end
            default: st = vrrf_pkg::STAT_MISUSE;
        endcase
        status_tally[st]++;
        if (!streamed && queue_it) begin
            o.status = st;
            o.data   = '0;
            o.last   = 1'b1;
            pending_outputs.push_back(o);
        end
    endfunction

    // Offers one item, with random idle cycles ahead of it, and waits for acceptance.
    task automatic offer_item(input logic [CMD_W-1:0] cmd, input logic [LEN_W-1:0] len,
                              input logic [BYTE_W-1:0] din, input logic [LEN_W-1:0] cap,
                              input logic fixed, input logic [STAT_W-1:0] want);
        fifo_out_t o;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, cap, din, len};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_ring_fifo(cmd, len, din, cap, !fixed);
        if (fixed) begin
            o.status = want;
            o.data   = '0;
            o.last   = 1'b1;
            pending_outputs.push_back(o);
        end
        items_sent++;
    endtask

    task automatic send(input logic [CMD_W-1:0] cmd, input logic [LEN_W-1:0] len,
                        input logic [BYTE_W-1:0] din, input logic [LEN_W-1:0] cap);
        offer_item(cmd, len, din, cap, 1'b0, vrrf_pkg::STAT_OK);
    endtask

    // Sender pause: nothing offered until every queued output has come out.
    task automatic wait_all_out();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_outputs.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [LEN_W-1:0] pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 70) return LEN_W'($urandom_range(8, 1));
        if (r < 90) return LEN_W'($urandom_range(32, 9));
        return LEN_W'($urandom_range(64, 33));
    endfunction

    function automatic logic [LEN_W-1:0] pick_cap();
        if ($urandom_range(99) < 70) return LEN_W'($urandom_range(127, 64));
        return LEN_W'($urandom_range(127));
    endfunction

    task automatic send_noise();
        send(CMD_W'($urandom_range(3)), LEN_W'($urandom_range(127)),
             BYTE_W'($urandom_range(255)), LEN_W'($urandom_range(127)));
    endtask

    task automatic close_open_record();
        while (shadow_open)
            send(vrrf_pkg::CMD_PUSH_BYTE, LEN_W'($urandom_range(127)),
                 BYTE_W'($urandom_range(255)), LEN_W'($urandom_range(127)));
    endtask

    // Header plus payload; now and then a pop or a stray header lands mid-record,
    // and a few records are left unfinished.
    task automatic push_record(input logic [LEN_W-1:0] len);
        int roll;
        send(vrrf_pkg::CMD_PUSH_HDR, len, BYTE_W'($urandom_range(255)),
             LEN_W'($urandom_range(127)));
        if (!shadow_open) return;
        for (int i = 0; i < int'(len); i++) begin
            roll = $urandom_range(99);
            if (roll < 2) return;
            if (roll < 8) send(vrrf_pkg::CMD_POP, '0, '0, pick_cap());
            else if (roll < 11) send(vrrf_pkg::CMD_PUSH_HDR, pick_len(), '0, '0);
            send(vrrf_pkg::CMD_PUSH_BYTE, LEN_W'($urandom_range(127)),
                 BYTE_W'($urandom_range(255)), LEN_W'($urandom_range(127)));
        end
    endtask

    task automatic random_step();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15) send_noise();
        else if (shadow_open) close_open_record();
        else if (roll < 60) push_record(pick_len());
        else send(vrrf_pkg::CMD_POP, LEN_W'($urandom_range(127)),
                  BYTE_W'($urandom_range(255)), pick_cap());
    endtask

    // Output side: check each accepted output, then choose next cycle's m_tready.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pending_outputs.size() == 0) begin
                    report_mismatch("output with nothing expected", {5'b0, m_tuser}, 8'h00);
                end else begin
                    fifo_out_t want;
                    want = pending_outputs.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", {5'b0, m_tuser}, {5'b0, want.status});
                    if (m_tdata !== want.data)
                        report_mismatch("data", m_tdata, want.data);
                    if (m_tlast !== want.last)
                        report_mismatch("last", {7'b0, m_tlast}, {7'b0, want.last});
                end
                outputs_checked++;
            end
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d outputs outstanding",
                     cycle_count, pending_outputs.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            offer_item(directed_rows[i].cmd, directed_rows[i].len, directed_rows[i].din,
                       directed_rows[i].cap, directed_rows[i].fixed, directed_rows[i].want);
        wait_all_out();

        // long output hold-off at the start of the first phase; the sender keeps going
        hold_asks <= hold_asks + 1;

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_pct_by_phase[ph];
            recv_stall_pct = recv_pct_by_phase[ph];
            phase_goal     = items_sent + PHASE_ITEMS;
            while (items_sent < phase_goal) random_step();
            wait_all_out();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Covered %0d items (directed rows, a long receiver hold, four stall mixes),",
                 items_sent);
        $display("%0d outputs checked; status counts ok %0d, full %0d, empty %0d, small %0d, misuse %0d.",
                 outputs_checked, status_tally[vrrf_pkg::STAT_OK],
                 status_tally[vrrf_pkg::STAT_FULL], status_tally[vrrf_pkg::STAT_EMPTY],
                 status_tally[vrrf_pkg::STAT_SMALL], status_tally[vrrf_pkg::STAT_MISUSE]);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/vrrf_pkg.sv
rtl/vrrf_datapath.sv
rtl/vrrf_ctrl.sv
rtl/variable_record_ring_fifo.sv
dv/variable_record_ring_fifo_tb.sv
